// ===== rtl/core/ils_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_pkg: shared types and codes for the indexed list store
// Command and status codes, field widths and the control word that the
// top level broadcasts along the chain of storage cells.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 5;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    // Wide enough for any length over the supported range of DEPTH (up to 1024).
    localparam int IDX_W   = 11;

    localparam int DEPTH_DEFAULT = 16;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND  = 3'd0,
        CMD_READ    = 3'd1,
        CMD_REPLACE = 3'd2,
        CMD_REMOVE  = 3'd3,
        CMD_INSERT  = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Control word seen by every cell in the same cycle.
    typedef struct packed {
        logic                     ins;     // shift up from pos, write val at pos
        logic                     del;     // shift down from pos
        logic                     wr;      // write val at wr_idx
        logic                     rd;      // drive the word at pos
        logic [IDX_W-1:0]         pos;
        logic [IDX_W-1:0]         wr_idx;
        logic signed [WORD_W-1:0] val;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== rtl/core/ils_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_cell: one storage cell of the list
// Holds the entry at a fixed index and takes its neighbour's word on a shift.
// ----------------------------------------------------------------------------
module ils_cell #(
    parameter int IDX = 0
) (
    input  wire                                 i_clk,
    input  wire ils_pkg::t_cell_ctl             i_ctl,
    input  wire logic signed [ils_pkg::WORD_W-1:0] i_left,
    input  wire logic signed [ils_pkg::WORD_W-1:0] i_right,
    output logic signed [ils_pkg::WORD_W-1:0]   o_data,
    output logic signed [ils_pkg::WORD_W-1:0]   o_rd_data
);
    import ils_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic signed [WORD_W-1:0] r_data;
    logic signed [WORD_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (MY_IDX > i_ctl.pos) begin
                n_data = i_left;
            end else if (MY_IDX == i_ctl.pos) begin
                n_data = i_ctl.val;
            end
        end else if (i_ctl.del) begin
            if (MY_IDX >= i_ctl.pos) begin
                n_data = i_right;
            end
        end else if (i_ctl.wr && (MY_IDX == i_ctl.wr_idx)) begin
            n_data = i_ctl.val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data    = r_data;
    assign o_rd_data = (i_ctl.rd && (MY_IDX == i_ctl.pos)) ? r_data : '0;

endmodule
`default_nettype wire

// ===== rtl/core/ils_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_chain: row of storage cells
// Links each cell to its neighbours and merges the cells' read outputs.
// ----------------------------------------------------------------------------
module ils_chain #(
    parameter int DEPTH = ils_pkg::DEPTH_DEFAULT
) (
    input  wire                               i_clk,
    input  wire ils_pkg::t_cell_ctl           i_ctl,
    output logic signed [ils_pkg::WORD_W-1:0] o_rd_data
);
    import ils_pkg::*;

    logic signed [WORD_W-1:0] w_data [DEPTH];
    logic signed [WORD_W-1:0] w_rd   [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [WORD_W-1:0] w_left;
        logic signed [WORD_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_ctl.val;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        ils_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (i_ctl),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_data    (w_data[g]),
            .o_rd_data (w_rd[g])
        );
    end

    // At most one cell drives a non-zero word.
    always_comb begin
        o_rd_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            o_rd_data = o_rd_data | w_rd[k];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/indexed_list_store_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_store_top: ordered list of signed words with insert and remove
// Command decoder, length register and result register over a chain of cells.
// ----------------------------------------------------------------------------
// The block keeps an ordered list of up to DEPTH signed 32-bit words. Each
// input transaction carries one command (append, read, replace, remove or
// insert) and produces exactly one output transaction carrying the word read
// (zero unless a successful read), the length after the command and a status
// code (done, store full, position out of range). A failed command changes
// nothing; unused command codes are ignored and report done. The words sit in
// a row of cells, one per index; every cell sees the decoded command in the
// same cycle and takes its own word, its left neighbour's word (insert) or its
// right neighbour's word (remove), so no command takes longer at a far
// position than at a near one. A result appears on the master side in the
// cycle after its command is accepted and sits in an output register; a new
// command is taken in the same cycle as the waiting result is taken, so with
// the master side always ready the block sustains one command per cycle, and
// a stall on the master side holds the slave side. Entries have no reset: only
// the length is cleared, and a read can only reach entries that have been
// written. Positions are five bits wide, so with DEPTH above 31 only the
// first 32 indexes can be addressed by read, replace, remove and insert.
// ----------------------------------------------------------------------------
module indexed_list_store_top #(
    parameter int DEPTH = ils_pkg::DEPTH_DEFAULT
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Fields from bit 0 up: command[2:0], position[7:3], value[39:8].
    input  wire  [ils_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0 up: read_value[31:0], count[36:32], status[38:37],
    // bit 39 zero.
    output logic [ils_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready
);
    import ils_pkg::*;

    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(DEPTH);

    // Input fields.
    logic [CMD_W-1:0]         w_cmd;
    logic [POS_W-1:0]         w_pos;
    logic signed [WORD_W-1:0] w_val;
    logic                     w_accept;

    assign w_cmd    = s_axis_tdata[CMD_W-1:0];
    assign w_pos    = s_axis_tdata[CMD_W+POS_W-1:CMD_W];
    assign w_val    = s_axis_tdata[CMD_W+POS_W+WORD_W-1:CMD_W+POS_W];
    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Length and result registers.
    logic [LEN_W-1:0]         r_len;
    logic [LEN_W-1:0]         n_len;
    logic                     r_out_valid;
    logic signed [WORD_W-1:0] r_rd_value;
    logic [COUNT_W-1:0]       r_count;
    t_status                  r_status;

    // Decode.
    t_cell_ctl                w_ctl;
    t_status                  w_status;
    logic signed [WORD_W-1:0] w_chain_rd;
    logic [CMP_W-1:0]         w_pos_c;
    logic [CMP_W-1:0]         w_len_c;
    logic                     w_full;
    logic                     w_pos_lt;
    logic                     w_pos_gt;

    assign w_pos_c  = CMP_W'(w_pos);
    assign w_len_c  = CMP_W'(r_len);
    assign w_full   = (r_len == LEN_FULL);
    assign w_pos_lt = (w_pos_c < w_len_c);
    assign w_pos_gt = (w_pos_c > w_len_c);

    always_comb begin
        w_ctl.ins    = 1'b0;
        w_ctl.del    = 1'b0;
        w_ctl.wr     = 1'b0;
        w_ctl.rd     = 1'b0;
        w_ctl.pos    = IDX_W'(w_pos);
        w_ctl.wr_idx = IDX_W'(w_pos);
        w_ctl.val    = w_val;
        w_status     = ST_DONE;
        n_len        = r_len;
        unique case (t_cmd'(w_cmd))
            CMD_APPEND: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.wr     = w_accept;
                    w_ctl.wr_idx = IDX_W'(r_len);
                    n_len        = r_len + 1'b1;
                end
            end
            CMD_READ: begin
                if (w_pos_lt) begin
                    w_ctl.rd = 1'b1;
                end else begin
                    w_status = ST_RANGE;
                end
            end
            CMD_REPLACE: begin
                if (w_pos_lt) begin
                    w_ctl.wr = w_accept;
                end else begin
                    w_status = ST_RANGE;
                end
            end
            CMD_REMOVE: begin
                if (w_pos_lt) begin
                    w_ctl.del = w_accept;
                    n_len     = r_len - 1'b1;
                end else begin
                    w_status = ST_RANGE;
                end
            end
            CMD_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_pos_gt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctl.ins = w_accept;
                    n_len     = r_len + 1'b1;
                end
            end
            default: begin
                // Unused codes leave everything untouched and report done.
            end
        endcase
    end

    ils_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .o_rd_data (w_chain_rd)
    );

    // A new command may enter when the result register is empty or is being
    // emptied in this cycle.
    assign s_axis_tready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_len       <= n_len;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each accepted command.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_value <= w_chain_rd;
            r_count    <= COUNT_W'(n_len);
            r_status   <= w_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {
        {(OUT_TDATA_W - WORD_W - COUNT_W - STAT_W){1'b0}},
        r_status,
        r_count,
        r_rd_value
    };

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_FULL)
        else $error("list length exceeds DEPTH");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd == CMD_APPEND) && !w_full)
        |=> (r_len == $past(r_len) + 1'b1))
        else $error("accepted append did not grow the list by one");

    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_FULL)) |-> (r_len == LEN_FULL))
        else $error("store-full result reported while the list is not full");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd == CMD_REMOVE) && w_pos_lt)
        |=> (r_len == $past(r_len) - 1'b1))
        else $error("accepted remove did not shrink the list by one");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("slave side stalled with an empty result register");

endmodule
`default_nettype wire

// ===== bench/indexed_list_store_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store_checker: result predictor and scoreboard for the list store
// Watches the command and result channels, keeps its own copy of the list,
// predicts the reply to every accepted command and compares replies in order.
// ----------------------------------------------------------------------------
module indexed_list_store_checker #(
    parameter int LIST_DEPTH = ils_pkg::DEPTH_DEFAULT
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Fields from bit 0 up: command[2:0], position[7:3], value[39:8].
    input  wire  [ils_pkg::IN_TDATA_W-1:0]   i_cmd_tdata,
    input  wire                              i_cmd_tvalid,
    input  wire                              i_cmd_tready,
    // Fields from bit 0 up: read_value[31:0], count[36:32], status[38:37].
    input  wire  [ils_pkg::OUT_TDATA_W-1:0]  i_rsp_tdata,
    input  wire                              i_rsp_tvalid,
    input  wire                              i_rsp_tready,
    output logic [31:0]                      o_mismatch_count = '0,
    output logic [31:0]                      o_outstanding = '0
);
    import ils_pkg::*;

    localparam int REPORT_LIMIT = 200;

    typedef struct packed {
        logic signed [WORD_W-1:0]  read_value;
        logic        [COUNT_W-1:0] count;
        logic        [STAT_W-1:0]  status;
    } t_list_reply;

    logic signed [WORD_W-1:0] list_words [LIST_DEPTH];
    int unsigned              list_len = 0;
    t_list_reply              awaited_replies [$];
    int unsigned              bad_count = 0;
    int unsigned              reports = 0;

    // Applies one command to the shadow list and returns the reply it earns.
    // A failed command leaves the list untouched.
    function automatic t_list_reply apply_list_command(
        input logic        [CMD_W-1:0]  cmd,
        input logic        [POS_W-1:0]  pos,
        input logic signed [WORD_W-1:0] val
    );
        t_list_reply reply;
        int unsigned k;
        reply.read_value = '0;
        reply.status     = ST_DONE;
        case (cmd)
            CMD_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    list_words[list_len] = val;
                    list_len++;
                end
            end
            CMD_READ: begin
                if (pos < list_len) reply.read_value = list_words[pos];
                else reply.status = ST_RANGE;
            end
            CMD_REPLACE: begin
                if (pos < list_len) list_words[pos] = val;
                else reply.status = ST_RANGE;
            end
            CMD_REMOVE: begin
                if (pos < list_len) begin
                    for (k = pos; k + 1 < list_len; k++) list_words[k] = list_words[k + 1];
                    list_len--;
                end else begin
                    reply.status = ST_RANGE;
                end
            end
            CMD_INSERT: begin
                // The full check takes precedence over the position check.
                if (list_len >= LIST_DEPTH) begin
                    reply.status = ST_FULL;
                end else if (pos > list_len) begin
                    reply.status = ST_RANGE;
                end else begin
                    for (k = list_len; k > pos; k--) list_words[k] = list_words[k - 1];
                    list_words[pos] = val;
                    list_len++;
                end
            end
            default: begin
            end
        endcase
        reply.count = COUNT_W'(list_len);
        return reply;
    endfunction

    always @(posedge i_clk) begin
        t_list_reply want;
        t_list_reply seen;
        if (!i_rst_n) begin
            list_len = 0;
            awaited_replies.delete();
        end else begin
            // Replies are checked before the new command is predicted, since a
            // reply leaving in this cycle always belongs to an older command.
            if (i_rsp_tvalid && i_rsp_tready) begin
                seen.read_value = i_rsp_tdata[WORD_W-1:0];
                seen.count      = i_rsp_tdata[WORD_W +: COUNT_W];
                seen.status     = i_rsp_tdata[WORD_W + COUNT_W +: STAT_W];
                if (awaited_replies.size() == 0) begin
                    bad_count++;
                    if (reports < REPORT_LIMIT) begin
                        reports++;
                        $display("%0t: unexpected result: expected none, actual %h",
                                 $time, seen);
                    end
                end else begin
                    want = awaited_replies.pop_front();
                    if (want !== seen) begin
                        bad_count++;
                        if (reports < REPORT_LIMIT) begin
                            reports++;
                            $display({"%0t: result mismatch: expected read_value %0d ",
                                      "count %0d status %0d, actual read_value %0d ",
                                      "count %0d status %0d"},
                                     $time, $signed(want.read_value), want.count,
                                     want.status, $signed(seen.read_value), seen.count,
                                     seen.status);
                        end
                    end
                end
            end
            if (i_cmd_tvalid && i_cmd_tready) begin
                awaited_replies.push_back(apply_list_command(
                    i_cmd_tdata[CMD_W-1:0],
                    i_cmd_tdata[CMD_W +: POS_W],
                    i_cmd_tdata[CMD_W + POS_W +: WORD_W]));
            end
        end
        o_mismatch_count <= bad_count;
        o_outstanding    <= awaited_replies.size();
    end

endmodule

// ===== bench/indexed_list_store_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store_top_tb: stimulus and verdict for the indexed list store
// Drives command transactions with random gaps and back-pressure, lets the
// checker predict and compare every result, and reports the outcome.
// ----------------------------------------------------------------------------
module indexed_list_store_top_tb;
    import ils_pkg::*;

    localparam int LIST_DEPTH       = DEPTH_DEFAULT;
    localparam int RESET_CYCLES     = 9;
    // Long enough for the output register to fill and the input to stall.
    localparam int LONG_HOLD_CYCLES = 80;
    // Far above the longest quiet stretch of a correct run (reset, long hold).
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int TAIL_CYCLES      = 8;
    localparam int PHASE_ONE_ITEMS  = 220;
    localparam int PHASE_TWO_ITEMS  = 220;
    localparam int PHASE_THREE_ITEMS = 210;
    localparam int MAX_POSITION     = (1 << POS_W) - 1;

    // Command codes that the block ignores.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_ODD = 32'sh5555_5555;
    localparam logic signed [WORD_W-1:0] WORD_EVEN = 32'shAAAA_AAAA;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    // Fields from bit 0 up: command[2:0], position[7:3], value[39:8].
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                    s_axis_tvalid = 1'b0;
    wire                     s_axis_tready;
    // Fields from bit 0 up: read_value[31:0], count[36:32], status[38:37],
    // bit 39 zero.
    wire  [OUT_TDATA_W-1:0]  m_axis_tdata;
    wire                     m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;

    wire  [31:0]             mismatch_count;
    wire  [31:0]             outstanding;

    // Idle chances in percent for the two sides, changed from phase to phase.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // The stimulus process asks for a long receiver hold by bumping a counter;
    // the receiver process notices the difference and counts the hold itself.
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;

    // Rough picture of the list length, kept only to steer the stimulus
    // towards positions that the list currently holds.
    int unsigned shadow_len = 0;
    bit          filling    = 1'b1;

    int unsigned quiet_cycles = 0;

    indexed_list_store_top #(
        .DEPTH(LIST_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    indexed_list_store_checker #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_tdata      (s_axis_tdata),
        .i_cmd_tvalid     (s_axis_tvalid),
        .i_cmd_tready     (s_axis_tready),
        .i_rsp_tdata      (m_axis_tdata),
        .i_rsp_tvalid     (m_axis_tvalid),
        .i_rsp_tready     (m_axis_tready),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    always #1 i_clk = ~i_clk;

    // Receiver: either serves a long hold requested by the stimulus, or is
    // ready at random according to the idle chance of the current phase.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_requests != hold_served) begin
            hold_served   <= hold_requests;
            hold_left     <= LONG_HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Watchdog: a run in which no transaction moves on either channel for
    // too long has hung, and is ended as a failure.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("indexed_list_store_top_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Follows the length after an accepted command and switches between
    // growing and shrinking the list when it reaches either end.
    function automatic void track_length(
        input logic [CMD_W-1:0] cmd,
        input logic [POS_W-1:0] pos
    );
        case (cmd)
            CMD_APPEND: if (shadow_len < LIST_DEPTH) shadow_len++;
            CMD_REMOVE: if (pos < shadow_len) shadow_len--;
            CMD_INSERT: if (shadow_len < LIST_DEPTH && pos <= shadow_len) shadow_len++;
            default: begin
            end
        endcase
        if (shadow_len == LIST_DEPTH) filling = 1'b0;
        else if (shadow_len == 0) filling = 1'b1;
        else if ($urandom_range(99, 0) < 2) filling = !filling;
    endfunction

    // Offers one command transaction, after a random gap, and holds it until
    // the block takes it. Valid stays high into the next call unless that
    // call opens a gap, so no step sees valid lowered and raised together.
    task automatic send_command(
        input logic        [CMD_W-1:0]  cmd,
        input logic        [POS_W-1:0]  pos,
        input logic signed [WORD_W-1:0] val
    );
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= {val, pos, cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        track_length(cmd, pos);
    endtask

    // The sender goes quiet until every predicted result has come back.
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // Mostly commands that fit the direction the list is moving in, with a
    // thin layer of arbitrary codes, the ignored ones among them.
    function automatic logic [CMD_W-1:0] pick_command();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 6) return CMD_W'($urandom_range(7, 0));
        if (filling) begin
            if (roll < 30) return CMD_APPEND;
            if (roll < 54) return CMD_INSERT;
            if (roll < 72) return CMD_READ;
            if (roll < 86) return CMD_REPLACE;
            return CMD_REMOVE;
        end
        if (roll < 14) return CMD_APPEND;
        if (roll < 22) return CMD_INSERT;
        if (roll < 40) return CMD_READ;
        if (roll < 54) return CMD_REPLACE;
        return CMD_REMOVE;
    endfunction

    // Positions inside the list most of the time, anything at all otherwise.
    function automatic logic [POS_W-1:0] pick_position(input logic [CMD_W-1:0] cmd);
        if ($urandom_range(99, 0) < 12) return POS_W'($urandom_range(MAX_POSITION, 0));
        if (cmd == CMD_INSERT) return POS_W'($urandom_range(shadow_len, 0));
        if (shadow_len == 0) return '0;
        return POS_W'($urandom_range(shadow_len - 1, 0));
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_value();
        if ($urandom_range(99, 0) < 10) begin
            case ($urandom_range(3, 0))
                0:       return WORD_MAX;
                1:       return WORD_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    // Boundary cases first: read, remove and insert on an empty list, an insert
    // at the length acting as an append, the ignored codes, filling the list to
    // the top, append and insert on a full list, and removal of the last entry.
    task automatic run_directed();
        int i;
        send_command(CMD_READ,    0, $urandom);
        send_command(CMD_REMOVE,  0, $urandom);
        send_command(CMD_INSERT,  1, $urandom);
        send_command(CMD_INSERT,  0, WORD_MAX);
        send_command(CMD_APPEND,  0, WORD_MIN);
        send_command(CMD_SPARE_A, MAX_POSITION, '1);
        send_command(CMD_SPARE_B, 0, $urandom);
        send_command(CMD_SPARE_C, MAX_POSITION, $urandom);
        send_command(CMD_REPLACE, 2, $urandom);
        send_command(CMD_REPLACE, 1, '1);
        send_command(CMD_INSERT,  1, '0);
        for (i = 3; i < LIST_DEPTH; i++) begin
            send_command(CMD_APPEND, 0, (i % 2 == 0) ? WORD_ODD : WORD_EVEN);
        end
        send_command(CMD_APPEND,  0, $urandom);
        // A full list is reported even though the position is also bad.
        send_command(CMD_INSERT,  MAX_POSITION, $urandom);
        send_command(CMD_REMOVE,  LIST_DEPTH - 1, $urandom);
    endtask

    // Random commands until enough of them have been ones the block acts on.
    task automatic run_random(input int unsigned item_target);
        int unsigned       acted;
        logic [CMD_W-1:0]  cmd;
        acted = 0;
        while (acted < item_target) begin
            cmd = pick_command();
            send_command(cmd, pick_position(cmd), pick_value());
            if (cmd <= CMD_INSERT) acted++;
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The sender rarely idles while the receiver often stalls.
        send_idle_pct = 7;
        recv_idle_pct = 52;
        run_directed();
        run_random(PHASE_ONE_ITEMS);
        pause_until_drained();

        // The other way round: a slow sender and an eager receiver.
        send_idle_pct = 52;
        recv_idle_pct = 7;
        run_random(PHASE_TWO_ITEMS);
        pause_until_drained();

        // No idling at all, opened by a long receiver hold while the sender
        // keeps offering, so that the block fills and stalls its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        run_random(PHASE_THREE_ITEMS);
        pause_until_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("indexed_list_store_top_tb: done, clean");
        end else begin
            $display("indexed_list_store_top_tb: done, errors");
        end
        $finish;
    end

endmodule
